// ===== src/accel_still_and_shake_detector_macros.svh =====
// Assertion macros for the still and shake detector.
// Used by the top level; the macros expect clk and arst_n in scope.
`ifndef ACCEL_STILL_AND_SHAKE_DETECTOR_MACROS_SVH
`define ACCEL_STILL_AND_SHAKE_DETECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/asd_pkg.sv =====
// Shared types and constants for the still and shake detector.
// No dependencies.
package asd_pkg;

	typedef struct packed {
		logic [15:0] still_min_mag;
		logic [15:0] still_max_mag;
		logic [15:0] still_delta_max;
		logic [15:0] still_hold_ms;
		logic [15:0] wake_delta_min;
		logic [15:0] stroke_min;
		logic [15:0] reversal_gap_ms;
		logic [15:0] shake_holdoff_ms;
	} cfg_t;

	typedef struct packed {
		logic shake_detected;
		logic woke_from_still;
		logic still_now;
	} result_t;

	typedef enum logic [2:0] {
		CFG_STILL_MIN_MAG    = 3'd0,
		CFG_STILL_MAX_MAG    = 3'd1,
		CFG_STILL_DELTA_MAX  = 3'd2,
		CFG_STILL_HOLD_MS    = 3'd3,
		CFG_WAKE_DELTA_MIN   = 3'd4,
		CFG_STROKE_MIN       = 3'd5,
		CFG_REVERSAL_GAP_MS  = 3'd6,
		CFG_SHAKE_HOLDOFF_MS = 3'd7
	} cfg_index_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_POS  = 2'd1,
		DIR_NEG  = 2'd2
	} dir_t;

	localparam cfg_t CFG_RESET = '{
		still_min_mag:    16'd3686,
		still_max_mag:    16'd4506,
		still_delta_max:  16'd205,
		still_hold_ms:    16'd1000,
		wake_delta_min:   16'd410,
		stroke_min:       16'd4096,
		reversal_gap_ms:  16'd500,
		shake_holdoff_ms: 16'd1000
	};

	localparam int ROOT_STEPS = 16;
	localparam int ROOT_STEP_W = $clog2(ROOT_STEPS);
	localparam int AXES = 3;

endpackage

// ===== src/asd_isqrt.sv =====
// Iterative floor integer square root of a 32-bit value, one result bit per cycle.
// Depends on asd_pkg.
module asd_isqrt
	import asd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] radicand,
	output logic        busy,
	output logic        done,
	output logic [15:0] root
);

	logic [31:0]            v_q;
	logic [31:0]            res_q;
	logic [31:0]            bit_q;
	logic [ROOT_STEP_W-1:0] step_q;
	logic                   busy_q;
	logic                   done_q;
	logic [31:0]            trial;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == ROOT_STEP_W'(ROOT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					done_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			res_q <= '0;
			bit_q <= 32'h4000_0000;
		end else if (busy_q) begin
			if (v_q >= trial) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = res_q[15:0];

endmodule

// ===== src/asd_track.sv =====
// Stillness, wake and shake tracking state with its next-state evaluation.
// Depends on asd_pkg.
module asd_track
	import asd_pkg::*;
#(
	parameter int REVERSALS_NEEDED = 4,
	parameter int WAKE_COOLDOWN_MS = 5000
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               commit,
	input  cfg_t               cfg,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic [31:0]        now_ms,
	input  logic [15:0]        mag,
	output result_t            res
);

	logic               seeded_q;
	logic signed [15:0] prev_x_q;
	logic signed [15:0] prev_y_q;
	logic [15:0]        prev_mag_q;
	logic [31:0]        still_start_q;
	logic               still_q;
	logic               was_still_q;
	logic [31:0]        last_wake_q;
	logic [31:0]        last_shake_q;
	logic [31:0]        last_rev_q;
	logic [3:0]         rev_cnt_q;
	dir_t               last_dir_q;

	logic [15:0]        mdelta;
	logic               near_one;
	logic               quiet;
	logic [31:0]        start_nxt;
	logic               still_nxt;
	logic               wake;
	logic [31:0]        last_wake_nxt;
	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic [16:0]        adx;
	logic [16:0]        ady;
	logic signed [16:0] d;
	logic [16:0]        ad;
	logic               stroke;
	dir_t               dir;
	logic               shake_open;
	logic [3:0]         cnt_a;
	dir_t               dir_a;
	logic [3:0]         cnt_inc;
	logic [3:0]         cnt_nxt;
	dir_t               dir_nxt;
	logic [31:0]        last_rev_nxt;
	logic [31:0]        last_shake_nxt;
	logic               shake;

	always_comb begin
		mdelta = (mag >= prev_mag_q) ? mag - prev_mag_q : prev_mag_q - mag;
		near_one = (mag >= cfg.still_min_mag) && (mag <= cfg.still_max_mag);
		quiet = mdelta <= cfg.still_delta_max;

		if (near_one && quiet) begin
			start_nxt = (still_start_q == 32'd0) ? now_ms : still_start_q;
			still_nxt = still_q || ((now_ms - start_nxt) >= {16'd0, cfg.still_hold_ms});
		end else begin
			start_nxt = 32'd0;
			still_nxt = 1'b0;
		end

		wake = was_still_q && !still_nxt && (mdelta >= cfg.wake_delta_min) &&
			((now_ms - last_wake_q) >= 32'(WAKE_COOLDOWN_MS));
		last_wake_nxt = wake ? now_ms : last_wake_q;

		dx = {accel_x[15], accel_x} - {prev_x_q[15], prev_x_q};
		dy = {accel_y[15], accel_y} - {prev_y_q[15], prev_y_q};
		adx = dx[16] ? 17'(-dx) : 17'(dx);
		ady = dy[16] ? 17'(-dy) : 17'(dy);
		d = (adx >= ady) ? dx : dy;
		ad = (adx >= ady) ? adx : ady;
		stroke = ad >= {1'b0, cfg.stroke_min};
		dir = (!d[16] && (d != 17'sd0)) ? DIR_POS : DIR_NEG;

		shake_open = (now_ms - last_shake_q) >= {16'd0, cfg.shake_holdoff_ms};
		cnt_a = rev_cnt_q;
		dir_a = last_dir_q;
		if (shake_open && (rev_cnt_q != 4'd0) &&
			((now_ms - last_rev_q) > {16'd0, cfg.reversal_gap_ms})) begin
			cnt_a = 4'd0;
			dir_a = DIR_NONE;
		end

		cnt_inc = cnt_a + 4'd1;
		cnt_nxt = cnt_a;
		dir_nxt = dir_a;
		last_rev_nxt = last_rev_q;
		last_shake_nxt = last_shake_q;
		shake = 1'b0;
		if (shake_open && stroke && (dir != dir_a)) begin
			last_rev_nxt = now_ms;
			if (cnt_inc >= 4'(REVERSALS_NEEDED)) begin
				last_shake_nxt = now_ms;
				cnt_nxt = 4'd0;
				dir_nxt = DIR_NONE;
				shake = 1'b1;
			end else begin
				cnt_nxt = cnt_inc;
				dir_nxt = dir;
			end
		end

		if (seeded_q) begin
			res.shake_detected = shake;
			res.woke_from_still = wake;
			res.still_now = still_nxt;
		end else begin
			res = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q      <= 1'b0;
			prev_x_q      <= '0;
			prev_y_q      <= '0;
			prev_mag_q    <= '0;
			still_start_q <= '0;
			still_q       <= 1'b0;
			was_still_q   <= 1'b0;
			last_wake_q   <= '0;
			last_shake_q  <= '0;
			last_rev_q    <= '0;
			rev_cnt_q     <= '0;
			last_dir_q    <= DIR_NONE;
		end else if (commit) begin
			seeded_q   <= 1'b1;
			prev_x_q   <= accel_x;
			prev_y_q   <= accel_y;
			prev_mag_q <= mag;
			if (seeded_q) begin
				still_start_q <= start_nxt;
				still_q       <= still_nxt;
				was_still_q   <= still_nxt;
				last_wake_q   <= last_wake_nxt;
				last_shake_q  <= last_shake_nxt;
				last_rev_q    <= last_rev_nxt;
				rev_cnt_q     <= cnt_nxt;
				last_dir_q    <= dir_nxt;
			end
		end
	end

endmodule

// ===== src/accel_still_and_shake_detector.sv =====
// Accelerometer still and shake detector: one result per sample. A new sample is
// accepted only while idle, once the previous result has been loaded for output.
// Each sample takes three passes of the shared squaring multiplier, the
// accumulate step and sixteen steps of the iterative square root.
// Reset is asynchronous and active low; it restores the default registers and
// clears all detector history, so the first sample after reset only seeds it.
`include "accel_still_and_shake_detector_macros.svh"

module accel_still_and_shake_detector
	import asd_pkg::*;
#(
	parameter int REVERSALS_NEEDED = 4,
	parameter int WAKE_COOLDOWN_MS = 5000
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic [31:0]        now_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               shake_detected,
	output logic               woke_from_still,
	output logic               still_now,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_ROOT = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t             state_q;
	cfg_t               cfg_q;
	logic signed [15:0] x_q;
	logic signed [15:0] y_q;
	logic signed [15:0] z_q;
	logic [31:0]        now_q;
	logic [1:0]         mul_step_q;
	logic signed [15:0] mul_op;
	logic signed [31:0] prod_s1;
	logic [31:0]        sq_q;
	logic [31:0]        sq_total;
	logic               root_start;
	logic               root_busy;
	logic               root_done;
	logic [15:0]        root;
	result_t            track_res;
	result_t            out_q;
	logic               out_valid_q;
	logic               in_accept;
	logic               out_load;

	assign in_accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign root_start = (state_q == ST_MUL) && (mul_step_q == 2'(AXES));
	assign sq_total = sq_q + 32'(prod_s1);
	assign cfg_ready = 1'b1;

	always_comb begin
		case (mul_step_q)
			2'd0:    mul_op = x_q;
			2'd1:    mul_op = y_q;
			default: mul_op = z_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mul_step_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q    <= ST_MUL;
						mul_step_q <= '0;
					end
				end
				ST_MUL: begin
					mul_step_q <= mul_step_q + 2'd1;
					if (root_start) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (root_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q   <= accel_x;
			y_q   <= accel_y;
			z_q   <= accel_z;
			now_q <= now_ms;
		end
		if (state_q == ST_MUL) begin
			prod_s1 <= mul_op * mul_op;
			if (mul_step_q == 2'd0) begin
				sq_q <= '0;
			end else begin
				sq_q <= sq_total;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_STILL_MIN_MAG:    cfg_q.still_min_mag    <= cfg_data;
				CFG_STILL_MAX_MAG:    cfg_q.still_max_mag    <= cfg_data;
				CFG_STILL_DELTA_MAX:  cfg_q.still_delta_max  <= cfg_data;
				CFG_STILL_HOLD_MS:    cfg_q.still_hold_ms    <= cfg_data;
				CFG_WAKE_DELTA_MIN:   cfg_q.wake_delta_min   <= cfg_data;
				CFG_STROKE_MIN:       cfg_q.stroke_min       <= cfg_data;
				CFG_REVERSAL_GAP_MS:  cfg_q.reversal_gap_ms  <= cfg_data;
				CFG_SHAKE_HOLDOFF_MS: cfg_q.shake_holdoff_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	asd_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sq_total),
		.busy     (root_busy),
		.done     (root_done),
		.root     (root)
	);

	asd_track #(
		.REVERSALS_NEEDED (REVERSALS_NEEDED),
		.WAKE_COOLDOWN_MS (WAKE_COOLDOWN_MS)
	) u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (out_load),
		.cfg     (cfg_q),
		.accel_x (x_q),
		.accel_y (y_q),
		.now_ms  (now_q),
		.mag     (root),
		.res     (track_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= track_res;
		end
	end

	assign out_valid = out_valid_q;
	assign shake_detected = out_q.shake_detected;
	assign woke_from_still = out_q.woke_from_still;
	assign still_now = out_q.still_now;

	`ASD_ASSERT_NEXT(a_busy_after_accept, in_accept, in_stall && !root_busy, "busy on accept")
	`ASD_ASSERT_NOW(a_load_when_free, out_load, !out_valid_q || !out_stall, "result overwritten")
	`ASD_ASSERT_NOW(a_root_done_in_root, root_done, state_q == ST_ROOT, "root done outside wait")

endmodule
